[hw/rtl/gasp_pkg.sv]
// Shared constants, types and helper functions of the grid path search block.
`timescale 1ns / 1ps
`default_nettype none
package gasp_pkg;

    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int DIM_W    = SIDE_W + 1;
    localparam int CELL_W   = 2 * SIDE_W;
    localparam int NCELLS   = MAX_SIDE * MAX_SIDE;
    localparam int COST_W   = 14;
    localparam int ORDER_W  = CELL_W;
    localparam int H_W      = 8;
    localparam int LEN_W    = 12;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 7;

    localparam logic [COST_W-1:0] COST_INF = '1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [CFG_A_W-1:0] CFG_ROWS      = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_COLS      = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_START_ROW = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_START_COL = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_GOAL_ROW  = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_GOAL_COL  = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_HMODE     = 3'd6;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_SEED,
        S_SCAN,
        S_PICK,
        S_NB,
        S_NB_CHK,
        S_WALK,
        S_WALK_D,
        S_RD1,
        S_RD2,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                is_open;
        logic                is_closed;
        logic [COST_W-1:0]   cost;
        logic [COST_W-1:0]   total;
        logic [ORDER_W-1:0]  order;
        logic [2:0]          dir;
    } node_t;

    localparam node_t NODE_INIT = '{is_open: 1'b0, is_closed: 1'b0, cost: COST_INF,
                                    total: COST_INF, order: '0, dir: '0};

    typedef struct packed {
        logic               inb;
        logic [SIDE_W-1:0]  row;
        logic [SIDE_W-1:0]  col;
        logic [H_W-1:0]     h;
        logic [1:0]         step;
    } move_t;

    typedef struct packed {
        logic               kind;
        logic               found;
        logic [LEN_W-1:0]   len;
        logic               step_valid;
        logic [2:0]         dir;
        logic [COST_W-1:0]  g;
        logic [H_W-1:0]     h;
        logic [COST_W-1:0]  f;
        logic               last;
    } result_t;

    function automatic logic [SIDE_W-1:0] abs_diff(input logic [SIDE_W-1:0] a,
                                                   input logic [SIDE_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [H_W-1:0] heur2(input logic [SIDE_W-1:0] r,
                                             input logic [SIDE_W-1:0] c,
                                             input logic [SIDE_W-1:0] gr,
                                             input logic [SIDE_W-1:0] gc,
                                             input logic mode);
        logic [SIDE_W:0] dr;
        logic [SIDE_W:0] dc;
        logic [SIDE_W:0] d;
        dr = {1'b0, abs_diff(r, gr)};
        dc = {1'b0, abs_diff(c, gc)};
        d  = mode ? (dr + dc) : ((dr > dc) ? dr : dc);
        return H_W'({d, 1'b0});
    endfunction

    function automatic logic signed [1:0] move_dr(input logic [2:0] d);
        logic signed [1:0] v;
        unique case (d)
            3'd0, 3'd4, 3'd5: v = -2'sd1;
            3'd1, 3'd6, 3'd7: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] move_dc(input logic [2:0] d);
        logic signed [1:0] v;
        unique case (d)
            3'd2, 3'd4, 3'd6: v = -2'sd1;
            3'd3, 3'd5, 3'd7: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] opp_dir(input logic [2:0] d);
        return d[2] ? (d ^ 3'd3) : (d ^ 3'd1);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/gasp_if.sv]
// Valid/ready channel interfaces for commands in and results out.
`timescale 1ns / 1ps
`default_nettype none
interface gasp_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [gasp_pkg::SIDE_W-1:0] cell_row;
    logic [gasp_pkg::SIDE_W-1:0] cell_col;
    logic                       cell_blocked;
    modport source(output valid, output cmd, output cell_row, output cell_col,
                   output cell_blocked, input ready);
    modport sink(input valid, input cmd, input cell_row, input cell_col,
                 input cell_blocked, output ready);
endinterface

interface gasp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic                        found;
    logic [gasp_pkg::LEN_W-1:0]  path_length;
    logic                        step_valid;
    logic [2:0]                  step_direction;
    logic [gasp_pkg::COST_W-1:0] step_cost_g;
    logic [gasp_pkg::H_W-1:0]    step_heuristic;
    logic [gasp_pkg::COST_W-1:0] step_total_f;
    logic                        last_step;
    modport source(output valid, output result_kind, output found, output path_length,
                   output step_valid, output step_direction, output step_cost_g,
                   output step_heuristic, output step_total_f, output last_step,
                   input ready);
    modport sink(input valid, input result_kind, input found, input path_length,
                 input step_valid, input step_direction, input step_cost_g,
                 input step_heuristic, input step_total_f, input last_step,
                 output ready);
endinterface
`default_nettype wire

[hw/rtl/gasp_move_unit.sv]
// Shared move unit: neighbor cell, bounds check, heuristic and step cost.
`timescale 1ns / 1ps
`default_nettype none
module gasp_move_unit (
    input  logic [gasp_pkg::SIDE_W-1:0] pos_row,
    input  logic [gasp_pkg::SIDE_W-1:0] pos_col,
    input  logic [2:0]                  dir,
    input  logic [gasp_pkg::DIM_W-1:0]  rows,
    input  logic [gasp_pkg::DIM_W-1:0]  cols,
    input  logic [gasp_pkg::SIDE_W-1:0] goal_row,
    input  logic [gasp_pkg::SIDE_W-1:0] goal_col,
    input  logic                        hmode,
    output gasp_pkg::move_t             mv
);
    import gasp_pkg::*;

    logic signed [SIDE_W+1:0] nr;
    logic signed [SIDE_W+1:0] nc;

    assign nr = $signed({2'b00, pos_row}) + (SIDE_W+2)'(move_dr(dir));
    assign nc = $signed({2'b00, pos_col}) + (SIDE_W+2)'(move_dc(dir));

    always_comb
    begin
        mv.row  = nr[SIDE_W-1:0];
        mv.col  = nc[SIDE_W-1:0];
        mv.inb  = !nr[SIDE_W+1] && !nc[SIDE_W+1] &&
                  (nr[SIDE_W:0] < rows) && (nc[SIDE_W:0] < cols);
        mv.h    = heur2(nr[SIDE_W-1:0], nc[SIDE_W-1:0], goal_row, goal_col, hmode);
        mv.step = dir[2] ? 2'd3 : 2'd2;
    end

endmodule
`default_nettype wire

[hw/rtl/grid_a_star_path_search.sv]
// Top level of the grid A* path search block.
// Commands arrive as beats on in_ch: load one obstacle cell, run a search, or read
// the next path step. Search and read beats each produce one result beat on out_ch;
// load beats and unknown commands produce none. Registers are written through the
// cfg_wr_en / cfg_addr / cfg_wr_data port; the user must write them only while the
// block is idle, as the block itself does not enforce this. A load beat is written
// to the obstacle map from S_IDLE. A read beat with a step left passes S_RD1,
// S_RD2 and S_EMIT: one path memory read and one node memory read, each with a
// registered output. A read beat with no step left goes straight to S_EMIT.
// A search first clears all 4096 cells of the node store, one cell per cycle, then
// does one expansion per popped cell. Each expansion scans all rows*cols cells of
// the node memory at one read per cycle for the cheapest open cell, then visits the
// eight neighbors through the shared move unit in S_NB and, if in bounds, S_NB_CHK.
// The found path is then walked back through S_WALK and S_WALK_D for each move.
// After reset all 4096 cells of the obstacle map are cleared in S_INIT; in_ch.ready
// is low during that sweep. Results wait in an output register; when the receiver
// stalls, load beats are still taken, and a finished result waits until it frees.
`timescale 1ns / 1ps
`default_nettype none
module grid_a_star_path_search (
    input  logic                         clk,
    input  logic                         rst_n,
    gasp_in_if.sink                      in_ch,
    gasp_out_if.source                   out_ch,
    input  logic                         cfg_wr_en,
    input  logic [gasp_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [gasp_pkg::CFG_D_W-1:0] cfg_wr_data
);
    import gasp_pkg::*;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic [SIDE_W-1:0] start_row_reg, start_col_reg, goal_row_reg, goal_col_reg;
    logic              hmode_reg;

    logic [CELL_W-1:0]  cnt_reg;
    logic [SIDE_W-1:0]  scan_r_reg, scan_c_reg;
    logic               scan_end_reg, pipe_v_reg, any_reg;
    logic [CELL_W-1:0]  pipe_addr_reg, best_addr_reg, p_reg;
    node_t              best_node_reg;
    logic [2:0]         dir_reg;
    logic [ORDER_W-1:0] ins_cnt_reg;
    logic [LEN_W-1:0]   path_n_reg, path_count_reg, rd_ptr_reg;
    result_t            res_reg, out_res_reg;
    logic               out_valid_reg;

    logic              blk_mem [NCELLS];
    node_t             node_mem [NCELLS];
    logic [CELL_W-1:0] path_mem [NCELLS];

    logic              blk_we, blk_wdata, blk_rd_reg;
    logic [CELL_W-1:0] blk_waddr;
    logic              node_we;
    logic [CELL_W-1:0] node_waddr, node_raddr;
    node_t             node_wdata, node_rd_reg;
    logic              path_we;
    logic [CELL_W-1:0] path_waddr, path_wdata, path_raddr, path_rd_reg;

    logic [DIM_W-1:0]  rows_eff, cols_eff;
    logic [CELL_W-1:0] start_idx, goal_idx;
    logic              start_ok, goal_ok, goal_hit, out_free, in_acc;
    logic [H_W-1:0]    start_h;
    logic [SIDE_W-1:0] mu_row, mu_col;
    logic [2:0]        mu_dir;
    move_t             mv;
    logic [COST_W-1:0] t_cost;
    logic              nb_upd, better;

    assign rows_eff  = (rows_reg == '0) ? DIM_W'(1) :
                       (rows_reg > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : rows_reg;
    assign cols_eff  = (cols_reg == '0) ? DIM_W'(1) :
                       (cols_reg > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : cols_reg;
    assign start_idx = {start_row_reg, start_col_reg};
    assign goal_idx  = {goal_row_reg, goal_col_reg};
    assign start_ok  = ({1'b0, start_row_reg} < rows_eff) && ({1'b0, start_col_reg} < cols_eff);
    assign goal_ok   = ({1'b0, goal_row_reg} < rows_eff) && ({1'b0, goal_col_reg} < cols_eff);
    assign goal_hit  = goal_ok && (best_addr_reg == goal_idx);
    assign start_h   = heur2(start_row_reg, start_col_reg, goal_row_reg, goal_col_reg,
                             hmode_reg);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_acc    = in_ch.valid && in_ch.ready;
    assign t_cost    = best_node_reg.cost + COST_W'(mv.step);
    assign nb_upd    = !blk_rd_reg && !node_rd_reg.is_closed && (t_cost < node_rd_reg.cost);
    assign better    = node_rd_reg.is_open &&
                       (!any_reg || (node_rd_reg.total < best_node_reg.total) ||
                        ((node_rd_reg.total == best_node_reg.total) &&
                         (node_rd_reg.order < best_node_reg.order)));

    gasp_move_unit u_move (
        .pos_row  (mu_row),
        .pos_col  (mu_col),
        .dir      (mu_dir),
        .rows     (rows_eff),
        .cols     (cols_eff),
        .goal_row (goal_row_reg),
        .goal_col (goal_col_reg),
        .hmode    (hmode_reg),
        .mv       (mv)
    );

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rd_reg <= blk_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_rd_reg <= path_mem[path_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == CELL_W'(NCELLS - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.cmd == CMD_SEARCH) state_next = S_CLR;
                    else if (in_ch.cmd == CMD_READ)
                        state_next = (rd_ptr_reg < path_count_reg) ? S_RD1 : S_EMIT;
                end
            end
            S_CLR:
            begin
                if (cnt_reg == CELL_W'(NCELLS - 1)) state_next = S_SEED;
            end
            S_SEED:   state_next = start_ok ? S_SCAN : S_EMIT;
            S_SCAN:
            begin
                if (scan_end_reg && !pipe_v_reg) state_next = S_PICK;
            end
            S_PICK:
            begin
                if (!any_reg) state_next = S_EMIT;
                else if (goal_hit) state_next = S_WALK;
                else state_next = S_NB;
            end
            S_NB:
            begin
                if (mv.inb) state_next = S_NB_CHK;
                else if (dir_reg == 3'd7) state_next = S_SCAN;
            end
            S_NB_CHK: state_next = (dir_reg == 3'd7) ? S_SCAN : S_NB;
            S_WALK:   state_next = (p_reg == start_idx) ? S_EMIT : S_WALK_D;
            S_WALK_D: state_next = S_WALK;
            S_RD1:    state_next = S_RD2;
            S_RD2:    state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free) state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        blk_we      = 1'b0;
        blk_waddr   = {in_ch.cell_row, in_ch.cell_col};
        blk_wdata   = in_ch.cell_blocked;
        node_we     = 1'b0;
        node_waddr  = cnt_reg;
        node_wdata  = NODE_INIT;
        node_raddr  = {mv.row, mv.col};
        path_we     = 1'b0;
        path_waddr  = path_n_reg;
        path_wdata  = p_reg;
        path_raddr  = path_count_reg - rd_ptr_reg - LEN_W'(1);
        mu_row      = best_addr_reg[CELL_W-1:SIDE_W];
        mu_col      = best_addr_reg[SIDE_W-1:0];
        mu_dir      = dir_reg;
        in_ch.ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_INIT:
            begin
                blk_we    = 1'b1;
                blk_waddr = cnt_reg;
                blk_wdata = 1'b0;
            end
            S_IDLE:
            begin
                blk_we = in_ch.valid && (in_ch.cmd == CMD_LOAD);
            end
            S_CLR:
            begin
                node_we = 1'b1;
            end
            S_SEED:
            begin
                node_we    = start_ok;
                node_waddr = start_idx;
                node_wdata = '{is_open: 1'b1, is_closed: 1'b0, cost: '0,
                               total: COST_W'(start_h), order: '0, dir: '0};
            end
            S_SCAN:
            begin
                node_raddr = {scan_r_reg, scan_c_reg};
            end
            S_PICK:
            begin
                node_we              = any_reg && !goal_hit;
                node_waddr           = best_addr_reg;
                node_wdata           = best_node_reg;
                node_wdata.is_open   = 1'b0;
                node_wdata.is_closed = 1'b1;
            end
            S_NB_CHK:
            begin
                node_we    = nb_upd;
                node_waddr = {mv.row, mv.col};
                node_wdata = '{is_open: 1'b1, is_closed: 1'b0, cost: t_cost,
                               total: t_cost + COST_W'(mv.h),
                               order: node_rd_reg.is_open ? node_rd_reg.order : ins_cnt_reg,
                               dir: dir_reg};
            end
            S_WALK:
            begin
                node_raddr = p_reg;
            end
            S_WALK_D:
            begin
                mu_row  = p_reg[CELL_W-1:SIDE_W];
                mu_col  = p_reg[SIDE_W-1:0];
                mu_dir  = opp_dir(node_rd_reg.dir);
                path_we = 1'b1;
            end
            S_RD1:
            begin
                node_raddr = path_rd_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            rows_reg       <= DIM_W'(MAX_SIDE);
            cols_reg       <= DIM_W'(MAX_SIDE);
            start_row_reg  <= '0;
            start_col_reg  <= '0;
            goal_row_reg   <= '0;
            goal_col_reg   <= '0;
            hmode_reg      <= 1'b1;
            cnt_reg        <= '0;
            scan_r_reg     <= '0;
            scan_c_reg     <= '0;
            scan_end_reg   <= 1'b0;
            pipe_v_reg     <= 1'b0;
            any_reg        <= 1'b0;
            pipe_addr_reg  <= '0;
            best_addr_reg  <= '0;
            best_node_reg  <= NODE_INIT;
            p_reg          <= '0;
            dir_reg        <= '0;
            ins_cnt_reg    <= '0;
            path_n_reg     <= '0;
            path_count_reg <= '0;
            rd_ptr_reg     <= '0;
            res_reg        <= '0;
            out_res_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    CFG_ROWS:      rows_reg      <= cfg_wr_data;
                    CFG_COLS:      cols_reg      <= cfg_wr_data;
                    CFG_START_ROW: start_row_reg <= cfg_wr_data[SIDE_W-1:0];
                    CFG_START_COL: start_col_reg <= cfg_wr_data[SIDE_W-1:0];
                    CFG_GOAL_ROW:  goal_row_reg  <= cfg_wr_data[SIDE_W-1:0];
                    CFG_GOAL_COL:  goal_col_reg  <= cfg_wr_data[SIDE_W-1:0];
                    CFG_HMODE:     hmode_reg     <= cfg_wr_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res_reg;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT, S_CLR:
                begin
                    cnt_reg <= cnt_reg + CELL_W'(1);
                end
                S_IDLE:
                begin
                    if (in_acc && (in_ch.cmd == CMD_READ) && !(rd_ptr_reg < path_count_reg))
                    begin
                        res_reg <= '{kind: 1'b1, found: 1'b0, len: '0, step_valid: 1'b0,
                                     dir: '0, g: '0, h: '0, f: '0, last: 1'b0};
                    end
                end
                S_SEED:
                begin
                    path_count_reg <= '0;
                    rd_ptr_reg     <= '0;
                    ins_cnt_reg    <= start_ok ? ORDER_W'(1) : '0;
                    res_reg        <= '0;
                    scan_r_reg     <= '0;
                    scan_c_reg     <= '0;
                    scan_end_reg   <= 1'b0;
                    pipe_v_reg     <= 1'b0;
                    any_reg        <= 1'b0;
                end
                S_SCAN:
                begin
                    pipe_v_reg    <= !scan_end_reg;
                    pipe_addr_reg <= {scan_r_reg, scan_c_reg};
                    if (!scan_end_reg)
                    begin
                        if ({1'b0, scan_c_reg} == cols_eff - DIM_W'(1))
                        begin
                            scan_c_reg <= '0;
                            if ({1'b0, scan_r_reg} == rows_eff - DIM_W'(1))
                                scan_end_reg <= 1'b1;
                            else
                                scan_r_reg <= scan_r_reg + SIDE_W'(1);
                        end
                        else
                        begin
                            scan_c_reg <= scan_c_reg + SIDE_W'(1);
                        end
                    end
                    if (pipe_v_reg && better)
                    begin
                        any_reg       <= 1'b1;
                        best_addr_reg <= pipe_addr_reg;
                        best_node_reg <= node_rd_reg;
                    end
                end
                S_PICK:
                begin
                    dir_reg    <= '0;
                    p_reg      <= goal_idx;
                    path_n_reg <= '0;
                    res_reg    <= '0;
                end
                S_NB:
                begin
                    if (!mv.inb)
                    begin
                        dir_reg <= dir_reg + 3'd1;
                        if (dir_reg == 3'd7)
                        begin
                            scan_r_reg   <= '0;
                            scan_c_reg   <= '0;
                            scan_end_reg <= 1'b0;
                            pipe_v_reg   <= 1'b0;
                            any_reg      <= 1'b0;
                        end
                    end
                end
                S_NB_CHK:
                begin
                    if (nb_upd && !node_rd_reg.is_open)
                        ins_cnt_reg <= ins_cnt_reg + ORDER_W'(1);
                    dir_reg <= dir_reg + 3'd1;
                    if (dir_reg == 3'd7)
                    begin
                        scan_r_reg   <= '0;
                        scan_c_reg   <= '0;
                        scan_end_reg <= 1'b0;
                        pipe_v_reg   <= 1'b0;
                        any_reg      <= 1'b0;
                    end
                end
                S_WALK:
                begin
                    if (p_reg == start_idx)
                    begin
                        path_count_reg <= path_n_reg;
                        res_reg        <= '{kind: 1'b0, found: 1'b1, len: path_n_reg,
                                            step_valid: 1'b0, dir: '0, g: '0, h: '0,
                                            f: '0, last: 1'b0};
                    end
                end
                S_WALK_D:
                begin
                    p_reg      <= {mv.row, mv.col};
                    path_n_reg <= path_n_reg + LEN_W'(1);
                end
                S_RD2:
                begin
                    res_reg.kind       <= 1'b1;
                    res_reg.found      <= 1'b0;
                    res_reg.len        <= '0;
                    res_reg.step_valid <= 1'b1;
                    res_reg.dir        <= node_rd_reg.dir;
                    res_reg.g          <= node_rd_reg.cost;
                    res_reg.h          <= H_W'(node_rd_reg.total - node_rd_reg.cost);
                    res_reg.f          <= node_rd_reg.total;
                    res_reg.last       <= ((rd_ptr_reg + LEN_W'(1)) == path_count_reg);
                    rd_ptr_reg         <= rd_ptr_reg + LEN_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.result_kind    = out_res_reg.kind;
    assign out_ch.found          = out_res_reg.found;
    assign out_ch.path_length    = out_res_reg.len;
    assign out_ch.step_valid     = out_res_reg.step_valid;
    assign out_ch.step_direction = out_res_reg.dir;
    assign out_ch.step_cost_g    = out_res_reg.g;
    assign out_ch.step_heuristic = out_res_reg.h;
    assign out_ch.step_total_f   = out_res_reg.f;
    assign out_ch.last_step      = out_res_reg.last;

`ifndef NO_ASSERTIONS
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD2) |-> (rd_ptr_reg < path_count_reg))
        else $error("Path step read beyond the stored path.");
    a_chk_after_nb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB_CHK) |-> ($past(state_reg) == S_NB))
        else $error("Neighbor check entered without a neighbor read.");
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !node_we)
        else $error("Node store written during the open set scan.");
`endif

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the grid A* path search block: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
    import gasp_pkg::*;

    localparam int GRID_N       = 64;
    localparam int unsigned INF = 32'hFFFF_FFFF;
    localparam int ITEM_TARGET  = 1100;
    localparam int CYCLE_LIMIT  = 8000000;
    localparam int SETTLE       = 12;

    localparam int STEP_DR [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
    localparam int STEP_DC [8] = '{0, 0, -1, 1, -1, 1, -1, 1};

    typedef struct packed {
        bit        kind;
        bit        found;
        bit [11:0] len;
        bit        step_valid;
        bit [2:0]  dir;
        bit [13:0] g;
        bit [7:0]  h;
        bit [13:0] f;
        bit        last;
    } search_beat_t;

    typedef struct {
        bit           is_cfg;
        logic [2:0]   idx;
        int           val;
        cmd_t         cmd;
        int           row;
        int           col;
        int           blk;
        bit           typed;
        search_beat_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_A_W-1:0] cfg_addr;
    logic [CFG_D_W-1:0] cfg_wr_data;

    gasp_in_if  in_ch();
    gasp_out_if out_ch();

    grid_a_star_path_search u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    bit          obstacle [GRID_N*GRID_N];
    int unsigned g_cost [GRID_N*GRID_N];
    int unsigned f_cost [GRID_N*GRID_N];
    bit          is_closed [GRID_N*GRID_N];
    bit          is_open [GRID_N*GRID_N];
    int unsigned entry_seq [GRID_N*GRID_N];
    int          came_dir [GRID_N*GRID_N];
    int          route [GRID_N*GRID_N];
    int unsigned route_len;
    int unsigned read_ptr;
    int unsigned seq_count;
    int unsigned reg_val [7];

    search_beat_t pending_q[$];
    stim_row_t    stim_table[$];
    int errors;
    int items_sent;
    int burst_left;
    longint cycles;

    function automatic int unsigned clamp_dim(input int unsigned v);
        if (v < 1) return 1;
        if (v > GRID_N) return GRID_N;
        return v;
    endfunction

    function automatic int unsigned dist2(input int r, input int c);
        int dr;
        int dc;
        dr = r - int'(reg_val[CFG_GOAL_ROW]);
        dc = c - int'(reg_val[CFG_GOAL_COL]);
        if (dr < 0) dr = -dr;
        if (dc < 0) dc = -dc;
        if (reg_val[CFG_HMODE] != 0) return 2 * (dr + dc);
        return 2 * ((dr > dc) ? dr : dc);
    endfunction

    function automatic bit run_astar();
        int unsigned rows;
        int unsigned cols;
        int s;
        int goal;
        int best;
        int unsigned bf;
        int unsigned bo;
        int p;
        int n;
        int nr;
        int nc;
        int k;
        int unsigned t;
        bit any;
        bit goal_ok;
        rows = clamp_dim(reg_val[CFG_ROWS]);
        cols = clamp_dim(reg_val[CFG_COLS]);
        route_len = 0;
        read_ptr = 0;
        seq_count = 0;
        for (int i = 0; i < GRID_N*GRID_N; i++)
        begin
            g_cost[i] = INF;
            f_cost[i] = INF;
            is_closed[i] = 0;
            is_open[i] = 0;
        end
        if (reg_val[CFG_START_ROW] >= rows || reg_val[CFG_START_COL] >= cols) return 0;
        goal_ok = reg_val[CFG_GOAL_ROW] < rows && reg_val[CFG_GOAL_COL] < cols;
        s = reg_val[CFG_START_ROW] * GRID_N + reg_val[CFG_START_COL];
        goal = reg_val[CFG_GOAL_ROW] * GRID_N + reg_val[CFG_GOAL_COL];
        g_cost[s] = 0;
        f_cost[s] = dist2(reg_val[CFG_START_ROW], reg_val[CFG_START_COL]);
        is_open[s] = 1;
        entry_seq[s] = seq_count++;
        forever
        begin
            any = 0;
            best = 0;
            bf = 0;
            bo = 0;
            for (int r = 0; r < rows; r++)
            begin
                for (int c = 0; c < cols; c++)
                begin
                    k = r * GRID_N + c;
                    if (is_open[k] && (!any || f_cost[k] < bf ||
                        (f_cost[k] == bf && entry_seq[k] < bo)))
                    begin
                        any = 1;
                        best = k;
                        bf = f_cost[k];
                        bo = entry_seq[k];
                    end
                end
            end
            if (!any) return 0;
            is_open[best] = 0;
            if (goal_ok && best == goal)
            begin
                n = 0;
                p = goal;
                while (p != s)
                begin
                    p = (p / GRID_N - STEP_DR[came_dir[p]]) * GRID_N
                        + (p % GRID_N - STEP_DC[came_dir[p]]);
                    n++;
                end
                route_len = n;
                p = goal;
                for (int i = n; i > 0; i--)
                begin
                    route[i-1] = p;
                    p = (p / GRID_N - STEP_DR[came_dir[p]]) * GRID_N
                        + (p % GRID_N - STEP_DC[came_dir[p]]);
                end
                return 1;
            end
            is_closed[best] = 1;
            for (int d = 0; d < 8; d++)
            begin
                nr = best / GRID_N + STEP_DR[d];
                nc = best % GRID_N + STEP_DC[d];
                if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
                k = nr * GRID_N + nc;
                if (obstacle[k] || is_closed[k]) continue;
                t = g_cost[best] + ((d < 4) ? 2 : 3);
                if (t < g_cost[k])
                begin
                    came_dir[k] = d;
                    g_cost[k] = t;
                    f_cost[k] = t + dist2(nr, nc);
                    if (!is_open[k])
                    begin
                        is_open[k] = 1;
                        entry_seq[k] = seq_count++;
                    end
                end
            end
        end
    endfunction

    function automatic bit predict_beat(input cmd_t cmd, input int r, input int c,
                                        input int b, output search_beat_t res);
        int k;
        bit ok;
        res = '0;
        case (cmd)
            CMD_LOAD:
            begin
                obstacle[r * GRID_N + c] = b[0];
                return 0;
            end
            CMD_SEARCH:
            begin
                ok = run_astar();
                res.found = ok;
                res.len = (route_len > 4095) ? 12'd4095 : route_len[11:0];
                return 1;
            end
            CMD_READ:
            begin
                res.kind = 1;
                if (read_ptr < route_len)
                begin
                    k = route[read_ptr];
                    res.step_valid = 1;
                    res.dir = came_dir[k][2:0];
                    res.g = (g_cost[k] > 16383) ? 14'h3FFF : g_cost[k][13:0];
                    res.h = (f_cost[k] - g_cost[k] > 255) ? 8'hFF
                                                          : 8'(f_cost[k] - g_cost[k]);
                    res.f = (f_cost[k] > 16383) ? 14'h3FFF : f_cost[k][13:0];
                    res.last = (read_ptr + 1 == route_len);
                    read_ptr++;
                end
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val[CFG_D_W-1:0];
        reg_val[idx] = (idx < CFG_START_ROW) ? (val & 7'h7F) :
                       (idx == CFG_HMODE) ? (val & 1) : (val & 6'h3F);
        @(posedge clk);
    endtask

    task automatic send(input cmd_t cmd, input int r, input int c, input int b,
                        input bit typed, input search_beat_t want);
        search_beat_t res;
        cfg_wr_en <= 1'b0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= cmd;
        in_ch.cell_row     <= r[5:0];
        in_ch.cell_col     <= c[5:0];
        in_ch.cell_blocked <= b[0];
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
        if (cmd != CMD_NONE) items_sent++;
        if (predict_beat(cmd, r, c, b, res))
            pending_q.insert(pending_q.size(), typed ? want : res);
    endtask

    function automatic search_beat_t beat_of(input bit kind, input bit found,
                                             input int len);
        search_beat_t v;
        v = '0;
        v.kind = kind;
        v.found = found;
        v.len = len[11:0];
        return v;
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input int val);
        stim_row_t row;
        row = '{is_cfg: 1'b1, idx: idx, val: val, cmd: CMD_NONE, row: 0, col: 0,
                blk: 0, typed: 1'b0, want: '0};
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_item(input cmd_t cmd, input int r, input int c, input int b,
                                     input bit typed, input search_beat_t want);
        stim_row_t row;
        row = '{is_cfg: 1'b0, idx: '0, val: 0, cmd: cmd, row: r, col: c,
                blk: b, typed: typed, want: want};
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void build_table();
        search_beat_t none;
        none = '0;
        add_item(CMD_READ, 0, 0, 0, 1, beat_of(1, 0, 0));
        add_item(CMD_SEARCH, 0, 0, 0, 1, beat_of(0, 1, 0));
        add_item(CMD_READ, 0, 0, 0, 1, beat_of(1, 0, 0));
        add_item(CMD_LOAD, 0, 0, 1, 0, none);
        add_item(CMD_SEARCH, 63, 63, 1, 1, beat_of(0, 1, 0));
        add_cfg(CFG_GOAL_ROW, 2);
        add_cfg(CFG_GOAL_COL, 2);
        add_item(CMD_SEARCH, 0, 0, 0, 0, none);
        repeat (3) add_item(CMD_READ, 0, 0, 0, 0, none);
        add_cfg(CFG_HMODE, 0);
        add_cfg(CFG_START_ROW, 63);
        add_cfg(CFG_START_COL, 63);
        add_cfg(CFG_GOAL_ROW, 61);
        add_cfg(CFG_GOAL_COL, 60);
        add_item(CMD_SEARCH, 0, 0, 0, 0, none);
        repeat (4) add_item(CMD_READ, 0, 0, 0, 0, none);
        add_item(CMD_NONE, 63, 63, 1, 0, none);
        add_cfg(CFG_ROWS, 2);
        add_cfg(CFG_COLS, 2);
        add_item(CMD_SEARCH, 0, 0, 0, 1, beat_of(0, 0, 0));
        add_cfg(CFG_START_ROW, 0);
        add_cfg(CFG_START_COL, 0);
        add_item(CMD_SEARCH, 0, 0, 0, 1, beat_of(0, 0, 0));
        add_cfg(CFG_GOAL_ROW, 1);
        add_cfg(CFG_GOAL_COL, 1);
        add_item(CMD_LOAD, 1, 1, 1, 0, none);
        add_item(CMD_SEARCH, 0, 0, 0, 1, beat_of(0, 0, 0));
        add_item(CMD_LOAD, 63, 63, 0, 0, none);
        add_cfg(CFG_ROWS, 0);
        add_cfg(CFG_COLS, 127);
        add_cfg(CFG_HMODE, 1);
        add_cfg(CFG_GOAL_ROW, 0);
        add_cfg(CFG_GOAL_COL, 63);
        add_item(CMD_SEARCH, 0, 0, 0, 0, none);
        repeat (3) add_item(CMD_READ, 0, 0, 0, 0, none);
    endfunction

    task automatic random_phase();
        search_beat_t none;
        int sel;
        int rows;
        int cols;
        int er;
        int ec;
        int r;
        int c;
        none = '0;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            rows = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(64, 127);
            cols = $urandom_range(0, 1);
        end
        else if (sel == 1)
        begin
            rows = $urandom_range(0, 1);
            cols = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(64, 127);
        end
        else
        begin
            rows = $urandom_range(1, 8);
            cols = $urandom_range(1, 8);
        end
        er = clamp_dim(rows);
        ec = clamp_dim(cols);
        wait_idle();
        cfg_write(CFG_ROWS, rows);
        cfg_write(CFG_COLS, cols);
        cfg_write(CFG_START_ROW, $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                           : $urandom_range(0, er - 1));
        cfg_write(CFG_START_COL, $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                           : $urandom_range(0, ec - 1));
        cfg_write(CFG_GOAL_ROW, $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                          : $urandom_range(0, er - 1));
        cfg_write(CFG_GOAL_COL, $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                          : $urandom_range(0, ec - 1));
        cfg_write(CFG_HMODE, $urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) send(CMD_READ, 0, 0, 0, 0, none);
        repeat ($urandom_range(5, 20))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
            end
            else
            begin
                r = $urandom_range(0, er - 1);
                c = $urandom_range(0, ec - 1);
            end
            send($urandom_range(0, 15) == 0 ? CMD_NONE : CMD_LOAD, r, c,
                 $urandom_range(0, 3) == 0, 0, none);
        end
        send(CMD_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63),
             $urandom_range(0, 1), 0, none);
        repeat (route_len + $urandom_range(0, 2))
        begin
            if ($urandom_range(0, 7) == 0)
                send(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1), 0, none);
            send(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 1), 0, none);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    int stall_mode;
    int stall_left;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(50, 400);
        end
        stall_left--;
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= $urandom_range(0, 1);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        search_beat_t got;
        search_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.result_kind, out_ch.found, out_ch.path_length,
                    out_ch.step_valid, out_ch.step_direction, out_ch.step_cost_g,
                    out_ch.step_heuristic, out_ch.step_total_f, out_ch.last_step};
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got != want)
                begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_NONE;
        in_ch.cell_row = '0;
        in_ch.cell_col = '0;
        in_ch.cell_blocked = 1'b0;
        out_ch.ready = 1'b0;
        errors = 0;
        items_sent = 0;
        burst_left = 0;
        cycles = 0;
        stall_left = 0;
        for (int i = 0; i < GRID_N*GRID_N; i++)
        begin
            obstacle[i] = 0;
            g_cost[i] = INF;
            f_cost[i] = INF;
            came_dir[i] = 0;
            route[i] = 0;
        end
        route_len = 0;
        read_ptr = 0;
        seq_count = 0;
        reg_val = '{64, 64, 0, 0, 0, 0, 1};
        build_table();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
            begin
                if (i == 0 || !stim_table[i-1].is_cfg) wait_idle();
                cfg_write(stim_table[i].idx, stim_table[i].val);
            end
            else
            begin
                send(stim_table[i].cmd, stim_table[i].row, stim_table[i].col,
                     stim_table[i].blk, stim_table[i].typed, stim_table[i].want);
            end
        end
        while (items_sent < ITEM_TARGET) random_phase();
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
